@@ hw/rtl/tts_pkg.sv @@
// Shared types and constants for the tick task scheduler with time-of-day clock.
// No dependencies; every other file imports this package.
package tts_pkg;

  localparam int unsigned DivW     = 10;
  localparam int unsigned CountW   = 32;
  localparam int unsigned MaskW    = 4;
  localparam int unsigned HoursW   = 5;
  localparam int unsigned MinutesW = 6;
  localparam int unsigned SecondsW = 6;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [SecondsW-1:0] SecLimit  = SecondsW'(60);
  localparam logic [MinutesW-1:0] MinLimit  = MinutesW'(60);
  localparam logic [HoursW-1:0]   HourLimit = HoursW'(24);

  localparam logic [DivW-1:0] PeriodShortRst  = DivW'(5);
  localparam logic [DivW-1:0] PeriodMediumRst = DivW'(50);
  localparam logic [DivW-1:0] PeriodLongRst   = DivW'(500);
  localparam logic [DivW-1:0] TicksPerSecRst  = DivW'(1000);

  // Task flag bit positions
  localparam int unsigned FlagMs     = 0;
  localparam int unsigned FlagShort  = 1;
  localparam int unsigned FlagMedium = 2;
  localparam int unsigned FlagLong   = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PERIOD_SHORT  = 3'd0,
    CFG_PERIOD_MEDIUM = 3'd1,
    CFG_PERIOD_LONG   = 3'd2,
    CFG_TICKS_PER_SEC = 3'd3,
    CFG_CLOCK_ENABLE  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [DivW-1:0] period_short;
    logic [DivW-1:0] period_medium;
    logic [DivW-1:0] period_long;
    logic [DivW-1:0] ticks_per_second;
    logic            clock_enable;
  } cfg_t;

  typedef struct packed {
    logic                tick;
    logic                task_ran;
    logic [MaskW-1:0]    poll_mask;
    logic                clear_new_day;
    logic                set_time;
    logic [HoursW-1:0]   load_hours;
    logic [MinutesW-1:0] load_minutes;
    logic [SecondsW-1:0] load_seconds;
  } in_item_t;

  typedef struct packed {
    logic [MaskW-1:0]    pending;
    logic                day_rolled;
    logic [CountW-1:0]   elapsed_ms;
    logic [CountW-1:0]   task_rate;
    logic [HoursW-1:0]   clock_hours;
    logic [MinutesW-1:0] clock_minutes;
    logic [SecondsW-1:0] clock_seconds;
  } out_item_t;

endpackage

@@ hw/rtl/tts_in_if.sv @@
// Input channel: valid/ready handshake plus the item fields.
// Depends on tts_pkg for field widths.
interface tts_in_if import tts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                tick;
  logic                task_ran;
  logic [MaskW-1:0]    poll_mask;
  logic                clear_new_day;
  logic                set_time;
  logic [HoursW-1:0]   load_hours;
  logic [MinutesW-1:0] load_minutes;
  logic [SecondsW-1:0] load_seconds;

  modport source (
    output valid, tick, task_ran, poll_mask, clear_new_day, set_time,
           load_hours, load_minutes, load_seconds,
    input  ready
  );
  modport sink (
    input  valid, tick, task_ran, poll_mask, clear_new_day, set_time,
           load_hours, load_minutes, load_seconds,
    output ready
  );
endinterface

@@ hw/rtl/tts_out_if.sv @@
// Result channel: valid/ready handshake plus the result fields.
// Depends on tts_pkg for field widths.
interface tts_out_if import tts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MaskW-1:0]    pending;
  logic                day_rolled;
  logic [CountW-1:0]   elapsed_ms;
  logic [CountW-1:0]   task_rate;
  logic [HoursW-1:0]   clock_hours;
  logic [MinutesW-1:0] clock_minutes;
  logic [SecondsW-1:0] clock_seconds;

  modport source (
    output valid, pending, day_rolled, elapsed_ms, task_rate,
           clock_hours, clock_minutes, clock_seconds,
    input  ready
  );
  modport sink (
    input  valid, pending, day_rolled, elapsed_ms, task_rate,
           clock_hours, clock_minutes, clock_seconds,
    output ready
  );
endinterface

@@ hw/rtl/tts_cfg_if.sv @@
// Configuration write channel: valid/ready, register index and write data.
// Depends on tts_pkg for widths.
interface tts_cfg_if import tts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DivW-1:0]    wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

@@ hw/rtl/tick_task_scheduler_rtc_core.sv @@
// Top level of the tick task scheduler with time-of-day clock.
// Depends on tts_pkg, tts_in_if, tts_out_if, tts_cfg_if, tts_cfg_regs, tts_state.
//
//   channel  role     payload
//   in_ch    sink     tick, task_ran, poll_mask, clear_new_day, set_time, load_*
//   out_ch   source   pending, day_rolled, elapsed_ms, task_rate, clock_*
//   cfg_ch   sink     index, wdata (always ready)
//
// Path: input register, then the state update, which writes the result
// register. One item per cycle sustained while out_ch.ready holds; the state
// update is the only loop. Synchronous active-low reset clears all state and
// the configuration to defaults. When the result is not taken the input
// register holds one more item, after which in_ch.ready drops.
module tick_task_scheduler_rtc_core import tts_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  tts_in_if.sink   in_ch,
  tts_out_if.source out_ch,
  tts_cfg_if.sink  cfg_ch
);

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      out_free;
  logic      adv;
  in_item_t  in_item;
  out_item_t res;
  cfg_t      cfg;

  assign out_free = !out_valid_r || out_ch.ready;
  assign adv      = in_valid_r && out_free;

  assign in_ch.ready  = !in_valid_r || adv;
  assign cfg_ch.ready = 1'b1;

  assign in_item.tick          = in_ch.tick;
  assign in_item.task_ran      = in_ch.task_ran;
  assign in_item.poll_mask     = in_ch.poll_mask;
  assign in_item.clear_new_day = in_ch.clear_new_day;
  assign in_item.set_time      = in_ch.set_time;
  assign in_item.load_hours    = in_ch.load_hours;
  assign in_item.load_minutes  = in_ch.load_minutes;
  assign in_item.load_seconds  = in_ch.load_seconds;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r <= in_item;
    end
  end

  tts_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid),
    .wr_idx  (cfg_ch.index),
    .wr_data (cfg_ch.wdata),
    .cfg     (cfg)
  );

  tts_state u_state (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pending       = out_item_r.pending;
  assign out_ch.day_rolled    = out_item_r.day_rolled;
  assign out_ch.elapsed_ms    = out_item_r.elapsed_ms;
  assign out_ch.task_rate     = out_item_r.task_rate;
  assign out_ch.clock_hours   = out_item_r.clock_hours;
  assign out_ch.clock_minutes = out_item_r.clock_minutes;
  assign out_ch.clock_seconds = out_item_r.clock_seconds;

  // an advanced item shows up as the next result
  a_adv_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_valid_r && out_item_r == $past(res)))
    else $error("advanced item not presented as result");

  // a waiting result blocks the state update
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !adv)
    else $error("state advanced over an untaken result");

  // reset empties both pipeline registers
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !in_valid_r))
    else $error("pipeline not empty after reset");

endmodule

@@ hw/rtl/tts_cfg_regs.sv @@
// Configuration register file: periods, ticks per second, clock enable.
// Depends on tts_pkg.
module tts_cfg_regs import tts_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [CfgIdxW-1:0] wr_idx,
  input  logic [DivW-1:0]    wr_data,
  output cfg_t               cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_short     <= PeriodShortRst;
      cfg_r.period_medium    <= PeriodMediumRst;
      cfg_r.period_long      <= PeriodLongRst;
      cfg_r.ticks_per_second <= TicksPerSecRst;
      cfg_r.clock_enable     <= 1'b1;
    end else if (wr_en) begin
      unique case (wr_idx)
        CFG_PERIOD_SHORT:  cfg_r.period_short     <= wr_data;
        CFG_PERIOD_MEDIUM: cfg_r.period_medium    <= wr_data;
        CFG_PERIOD_LONG:   cfg_r.period_long      <= wr_data;
        CFG_TICKS_PER_SEC: cfg_r.ticks_per_second <= wr_data;
        CFG_CLOCK_ENABLE:  cfg_r.clock_enable     <= wr_data[0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/tts_state.sv @@
// Scheduler state: tick count, dividers, flags, run count, rate and clock.
// Computes one result per advanced item and commits the state. Depends on tts_pkg.
module tts_state import tts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t res
);

  typedef struct packed {
    logic [DivW-1:0] cnt;
    logic            roll;
  } div_step_t;

  function automatic div_step_t step_div(input logic [DivW-1:0] cnt,
                                         input logic [DivW-1:0] period);
    div_step_t       r;
    logic [DivW-1:0] nx;
    nx = cnt + 1'b1;  // wraps within the divider width
    if (nx >= period) begin
      r.cnt  = '0;
      r.roll = 1'b1;
    end else begin
      r.cnt  = nx;
      r.roll = 1'b0;
    end
    return r;
  endfunction

  logic [CountW-1:0]   tick_count_r, tick_count_nxt;
  logic [DivW-1:0]     short_div_r, short_div_nxt;
  logic [DivW-1:0]     medium_div_r, medium_div_nxt;
  logic [DivW-1:0]     long_div_r, long_div_nxt;
  logic [DivW-1:0]     second_div_r, second_div_nxt;
  logic [MaskW-1:0]    task_flags_r, task_flags_nxt;
  logic                day_flag_r, day_flag_nxt;
  logic [CountW-1:0]   run_count_r, run_count_nxt;
  logic [CountW-1:0]   rate_latch_r, rate_latch_nxt;
  logic [SecondsW-1:0] seconds_r, seconds_nxt;
  logic [MinutesW-1:0] minutes_r, minutes_nxt;
  logic [HoursW-1:0]   hours_r, hours_nxt;

  div_step_t           ds_short, ds_medium, ds_long, ds_second;
  logic [MaskW-1:0]    flags;
  logic                day;
  logic [CountW-1:0]   run;
  logic [SecondsW-1:0] sec, sec_inc;
  logic [MinutesW-1:0] mins, min_inc;
  logic [HoursW-1:0]   hrs, hr_inc;

  always_comb begin
    ds_short  = step_div(short_div_r, cfg.period_short);
    ds_medium = step_div(medium_div_r, cfg.period_medium);
    ds_long   = step_div(long_div_r, cfg.period_long);
    ds_second = step_div(second_div_r, cfg.ticks_per_second);

    // time load comes before the tick
    hrs  = item.set_time ? item.load_hours   : hours_r;
    mins = item.set_time ? item.load_minutes : minutes_r;
    sec  = item.set_time ? item.load_seconds : seconds_r;

    sec_inc = sec + 1'b1;
    min_inc = mins + 1'b1;
    hr_inc  = hrs + 1'b1;

    tick_count_nxt = tick_count_r;
    short_div_nxt  = short_div_r;
    medium_div_nxt = medium_div_r;
    long_div_nxt   = long_div_r;
    second_div_nxt = second_div_r;
    flags          = task_flags_r;
    day            = day_flag_r;
    run            = run_count_r;
    rate_latch_nxt = rate_latch_r;

    if (item.tick) begin
      tick_count_nxt    = tick_count_r + 1'b1;
      short_div_nxt     = ds_short.cnt;
      medium_div_nxt    = ds_medium.cnt;
      long_div_nxt      = ds_long.cnt;
      second_div_nxt    = ds_second.cnt;
      flags[FlagMs]     = 1'b1;
      flags[FlagShort]  = flags[FlagShort]  | ds_short.roll;
      flags[FlagMedium] = flags[FlagMedium] | ds_medium.roll;
      flags[FlagLong]   = flags[FlagLong]   | ds_long.roll;
      if (ds_second.roll) begin
        rate_latch_nxt = run_count_r;
        run            = '0;
        if (cfg.clock_enable) begin
          // carry chain; a unit at or above its limit wraps to zero
          if (sec_inc >= SecLimit) begin
            sec = '0;
            if (min_inc >= MinLimit) begin
              mins = '0;
              if (hr_inc >= HourLimit) begin
                hrs = '0;
                day = 1'b1;
              end else begin
                hrs = hr_inc;
              end
            end else begin
              mins = min_inc;
            end
          end else begin
            sec = sec_inc;
          end
        end
      end
    end

    run_count_nxt  = run + CountW'(item.task_ran);
    task_flags_nxt = flags & ~item.poll_mask;
    day_flag_nxt   = item.clear_new_day ? 1'b0 : day;
    seconds_nxt    = sec;
    minutes_nxt    = mins;
    hours_nxt      = hrs;

    res.pending       = flags & item.poll_mask;
    res.day_rolled    = day;
    res.elapsed_ms    = tick_count_nxt;
    res.task_rate     = rate_latch_nxt;
    res.clock_hours   = hrs;
    res.clock_minutes = mins;
    res.clock_seconds = sec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
      short_div_r  <= '0;
      medium_div_r <= '0;
      long_div_r   <= '0;
      second_div_r <= '0;
      task_flags_r <= '0;
      day_flag_r   <= 1'b0;
      run_count_r  <= '0;
      rate_latch_r <= '0;
      seconds_r    <= '0;
      minutes_r    <= '0;
      hours_r      <= '0;
    end else if (adv) begin
      tick_count_r <= tick_count_nxt;
      short_div_r  <= short_div_nxt;
      medium_div_r <= medium_div_nxt;
      long_div_r   <= long_div_nxt;
      second_div_r <= second_div_nxt;
      task_flags_r <= task_flags_nxt;
      day_flag_r   <= day_flag_nxt;
      run_count_r  <= run_count_nxt;
      rate_latch_r <= rate_latch_nxt;
      seconds_r    <= seconds_nxt;
      minutes_r    <= minutes_nxt;
      hours_r      <= hours_nxt;
    end
  end

endmodule
